// ===== src/bfs_vo_pkg.sv =====
// Shared types and fixed field widths for the breadth-first visit-order core.
`default_nettype none

package bfs_vo_pkg;

  // Fixed payload widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned VAL_W  = 10;
  localparam int unsigned OFF_W  = 10;
  localparam int unsigned NB_W   = 6;
  localparam int unsigned OUT_W  = 6;

  // Request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_LIST_START = 2'd0,
    MODE_NEIGHBOR   = 2'd1,
    MODE_WALK       = 2'd2,
    MODE_CLEAR      = 2'd3
  } mode_t;

  // Walk sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_DEQ_WAIT,
    ST_LS_LO,
    ST_LS_HI,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== src/bfs_vo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfs_vo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/bfs_visit_order_core.sv =====
// Top level of the breadth-first visit-order core: loads, walk sequencer, memories.
`default_nettype none

// Breadth-first walk over a graph held as compressed adjacency lists. Mode 0
// writes a list start offset (entry NODES closes the last list), mode 1 writes a
// neighbor into the edge store, mode 3 clears every visited mark, and mode 2
// walks from a start node, sending one result per visited node in visit order
// with out_last set on the final one. Visited marks persist between walks.
// Loads and the clear keep the core idle. A walk holds in_ready low until its
// last result is transferred. Per visited node it dequeues the node, reads both
// list bounds, then reads and checks each edge in turn, and offers the result
// until out_ready takes it: the sequencer reads the queue, the list start table
// and the edge store through one read port each, one access per cycle. Reading
// a list start or edge entry that was never written gives an undefined walk.
module bfs_visit_order_core #(
  parameter int unsigned NODES = 64,
  parameter int unsigned EDGES = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bfs_vo_pkg::MODE_W-1:0] in_mode,
  input  wire logic [bfs_vo_pkg::IDX_W-1:0]  in_index,
  input  wire logic [bfs_vo_pkg::VAL_W-1:0]  in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bfs_vo_pkg::OUT_W-1:0]       out_visited_node,
  output logic                               out_last
);

  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned CW  = $clog2(NODES + 1);
  localparam int unsigned LAW = $clog2(NODES + 1);
  localparam int unsigned EAW = $clog2(EDGES);
  localparam int unsigned OW  = bfs_vo_pkg::OFF_W;

  bfs_vo_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]      node_r, node_nxt;
  logic [OW-1:0]      e_r, e_nxt;
  logic [OW-1:0]      hi_r, hi_nxt;
  logic [CW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      tail_r, tail_nxt;
  logic [NODES-1:0]   visited_r, visited_nxt;

  // Memory ports
  logic                      ls_we;
  logic [LAW-1:0]            ls_raddr;
  logic [OW-1:0]             ls_rdata;
  logic                      nb_we;
  logic [EAW-1:0]            nb_raddr;
  logic [bfs_vo_pkg::NB_W-1:0] nb_rdata;
  logic                      q_we;
  logic [NW-1:0]             q_waddr;
  logic [NW-1:0]             q_wdata;
  logic [NW-1:0]             q_rdata;

  logic        in_xfer;
  logic        nb_ok;
  bfs_vo_pkg::mode_t mode;

  // Saturate an offset to the edge store size
  function automatic logic [OW-1:0] clamp_off(input logic [OW-1:0] off);
    logic [OW-1:0] res;
    res = off;
    if (32'(off) > EDGES) begin
      res = OW'(EDGES);
    end
    return res;
  endfunction

  assign mode    = bfs_vo_pkg::mode_t'(in_mode);
  assign in_xfer = in_valid && in_ready;
  assign nb_ok   = (32'(nb_rdata) < NODES) && !visited_r[NW'(nb_rdata)] &&
                   (32'(tail_r) < NODES);

  // Load writes go straight to the stores
  assign ls_we = in_xfer && (mode == bfs_vo_pkg::MODE_LIST_START) &&
                 (32'(in_index) <= NODES);
  assign nb_we = in_xfer && (mode == bfs_vo_pkg::MODE_NEIGHBOR) &&
                 (32'(in_index) < EDGES);

  bfs_vo_ram #(.WIDTH(OW), .DEPTH(NODES + 1)) u_list_start (
    .clk   (clk),
    .we    (ls_we),
    .waddr (LAW'(in_index)),
    .wdata (in_value),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  bfs_vo_ram #(.WIDTH(bfs_vo_pkg::NB_W), .DEPTH(EDGES)) u_neighbor (
    .clk   (clk),
    .we    (nb_we),
    .waddr (EAW'(in_index)),
    .wdata (in_value[bfs_vo_pkg::NB_W-1:0]),
    .raddr (nb_raddr),
    .rdata (nb_rdata)
  );

  bfs_vo_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r[NW-1:0]),
    .rdata (q_rdata)
  );

  // State and walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfs_vo_pkg::ST_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      visited_r <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      visited_r <= visited_nxt;
    end
    node_r <= node_nxt;
    e_r    <= e_nxt;
    hi_r   <= hi_nxt;
  end

  // Sequencer: next state, memory controls and result channel
  always_comb begin
    state_nxt   = state_r;
    node_nxt    = node_r;
    e_nxt       = e_r;
    hi_nxt      = hi_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    visited_nxt = visited_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    q_we        = 1'b0;
    q_waddr     = tail_r[NW-1:0];
    q_wdata     = NW'(nb_rdata);
    ls_raddr    = LAW'(node_r);
    nb_raddr    = EAW'(e_r);

    unique case (state_r)
      bfs_vo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == bfs_vo_pkg::MODE_CLEAR) begin
            visited_nxt = '0;
          end else if ((mode == bfs_vo_pkg::MODE_WALK) && (32'(in_index) < NODES)) begin
            // Seed the queue with the start node
            q_we                        = 1'b1;
            q_waddr                     = '0;
            q_wdata                     = NW'(in_index);
            visited_nxt[NW'(in_index)]  = 1'b1;
            head_nxt                    = '0;
            tail_nxt                    = CW'(1);
            state_nxt                   = bfs_vo_pkg::ST_DEQ;
          end
        end
      end

      bfs_vo_pkg::ST_DEQ: begin
        // Queue read of the head entry is under way
        state_nxt = bfs_vo_pkg::ST_DEQ_WAIT;
      end

      bfs_vo_pkg::ST_DEQ_WAIT: begin
        node_nxt  = q_rdata;
        head_nxt  = head_r + CW'(1);
        ls_raddr  = LAW'(q_rdata);
        state_nxt = bfs_vo_pkg::ST_LS_LO;
      end

      bfs_vo_pkg::ST_LS_LO: begin
        e_nxt     = clamp_off(ls_rdata);
        ls_raddr  = LAW'(32'(node_r) + 1);
        state_nxt = bfs_vo_pkg::ST_LS_HI;
      end

      bfs_vo_pkg::ST_LS_HI: begin
        hi_nxt    = clamp_off(ls_rdata);
        state_nxt = bfs_vo_pkg::ST_SCAN_RD;
      end

      bfs_vo_pkg::ST_SCAN_RD: begin
        // Fetch the next neighbor, or finish the list
        if (e_r < hi_r) begin
          state_nxt = bfs_vo_pkg::ST_SCAN_CHK;
        end else begin
          state_nxt = bfs_vo_pkg::ST_EMIT;
        end
      end

      bfs_vo_pkg::ST_SCAN_CHK: begin
        // Queue and mark a fresh neighbor
        if (nb_ok) begin
          q_we                       = 1'b1;
          visited_nxt[NW'(nb_rdata)] = 1'b1;
          tail_nxt                   = tail_r + CW'(1);
        end
        e_nxt     = e_r + OW'(1);
        state_nxt = bfs_vo_pkg::ST_SCAN_RD;
      end

      bfs_vo_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (head_r == tail_r) begin
            state_nxt = bfs_vo_pkg::ST_IDLE;
          end else begin
            state_nxt = bfs_vo_pkg::ST_DEQ;
          end
        end
      end

      default: begin
        state_nxt = bfs_vo_pkg::ST_IDLE;
      end
    endcase
  end

  // Result payload: the node just scanned, last when the queue has drained
  assign out_visited_node = bfs_vo_pkg::OUT_W'(node_r);
  assign out_last         = (head_r == tail_r);

endmodule

`default_nettype wire
